### rtl/poq_pkg.sv
// Shared types and codes for the price-ordered order queue.
package poq_pkg;

  typedef enum logic [2:0] {
    ACT_INS_BUY  = 3'd0,
    ACT_INS_SELL = 3'd1,
    ACT_LOOKUP   = 3'd2,
    ACT_REMOVE   = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] trader;
    logic [19:0] order;
    logic [23:0] qty;
    logic [23:0] price;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_trader;
    logic [19:0] found_order;
    logic [23:0] found_qty;
    logic [23:0] found_price;
    logic        found_side;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] trader;
    logic [19:0] order;
    logic [23:0] qty;
    logic [23:0] price;
    logic        side;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t item;
  } cell_ctrl_t;

endpackage

### rtl/poq_cell.sv
// One slot of the sorted order chain: compare, hold, shift in from either neighbor.
module poq_cell import poq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       left_keep_i,
  input  entry_t     left_entry_i,
  input  entry_t     right_entry_i,
  input  logic       match_before_i,
  output logic       keep_o,
  output logic       match_before_o,
  output logic       first_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;
  logic   ahead;
  logic   match;

  always_comb begin
    if (ctrl_i.item.side) begin
      ahead = entry_q.price > ctrl_i.item.price;
    end else begin
      ahead = entry_q.price >= ctrl_i.item.price;
    end
  end

  assign keep_o         = occ_i & ahead;
  assign match          = occ_i & (entry_q.trader == ctrl_i.item.trader) &
                          (entry_q.order == ctrl_i.item.order);
  assign match_before_o = match_before_i | match;
  assign first_o        = match & ~match_before_i;
  assign entry_o        = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? ctrl_i.item : left_entry_i;
      end
    end else if (ctrl_i.remove && match_before_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/price_ordered_order_queue.sv
// Top level of the price-ordered order queue: command register, cell chain, result register.
//
// Input beats carry an action (insert buy, insert sell, lookup, remove, clear) with
// trader id, order id, quantity and price. Every input beat yields exactly one output
// beat with a status and, for a successful lookup, the fields of the matched entry.
// The store is a chain of DEPTH cells sorted by descending price; all cells compare
// against the command at once and all shift together toward or away from the front.
// An item is taken into the command register and executed from there once the output
// register can take its result, which is then held in the output register; no new item
// is accepted meanwhile. in_stall_o is high while a command sits in the command register.
// A finished result waits in the output register; a new item is still accepted then,
// and its execution holds until the output register is taken.
// Reset empties the store (entry count to zero) and drops any pending command and
// result; no clearing pass is needed.
module price_ordered_order_queue import poq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  in_beat_t       cmd_q;
  logic           busy_q;
  logic           out_valid_q;
  out_beat_t      out_q, res;
  logic [CntW-1:0] count_q, count_d;

  logic           exec;
  logic           full;
  logic           found;
  cell_ctrl_t     ctrl;
  entry_t         entries [DEPTH];
  entry_t         hit_entry;
  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] first;
  logic [DEPTH:0]   matched;

  assign exec = busy_q & ~(out_valid_q & out_stall_i);
  assign full = (count_q == CntW'(DEPTH));

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_comb begin
    ctrl.item.trader = cmd_q.trader;
    ctrl.item.order  = cmd_q.order;
    ctrl.item.qty    = cmd_q.qty;
    ctrl.item.price  = cmd_q.price;
    ctrl.item.side   = (cmd_q.action == ACT_INS_SELL);
    ctrl.insert      = exec & ~full &
                       ((cmd_q.action == ACT_INS_BUY) || (cmd_q.action == ACT_INS_SELL));
    ctrl.remove      = exec & (cmd_q.action == ACT_REMOVE);
  end

  assign matched[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic   occ;
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = Idx < count_q;

    if (i == 0) begin : g_front
      assign left_keep  = 1'b1;
      assign left_entry = ctrl.item;
    end else begin : g_mid
      assign left_keep  = keep[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_rear
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    poq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ),
      .left_keep_i   (left_keep),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .match_before_i(matched[i]),
      .keep_o        (keep[i]),
      .match_before_o(matched[i+1]),
      .first_o       (first[i]),
      .entry_o       (entries[i])
    );
  end

  assign found = matched[DEPTH];

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_entry = hit_entry | (entries[i] & {$bits(entry_t){first[i]}});
    end
  end

  always_comb begin
    res     = '0;
    count_d = count_q;
    unique case (action_e'(cmd_q.action))
      ACT_INS_BUY, ACT_INS_SELL: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          count_d    = count_q + CntW'(1);
        end
      end
      ACT_LOOKUP: begin
        if (found) begin
          res.status       = ST_OK;
          res.found_trader = hit_entry.trader;
          res.found_order  = hit_entry.order;
          res.found_qty    = hit_entry.qty;
          res.found_price  = hit_entry.price;
          res.found_side   = hit_entry.side;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          res.status = ST_OK;
          count_d    = count_q - CntW'(1);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: begin
        res.status = ST_OK;
        count_d    = '0;
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= in_beat_i;
    end
    if (exec) begin
      out_q <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !exec |=> busy_q && $stable(cmd_q))
    else $error("pending command lost");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("executed command left no result");

  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable(count_q))
    else $error("entry count moved without a command");

  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first) && (found == (first != '0)))
    else $error("first-match select not one-hot");

endmodule
